// ----- hw/rtl/slcd_pkg.sv -----
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants for the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int unsigned HEADER_BYTES = 4;
  localparam int unsigned HDR_IDX_W    = $clog2(HEADER_BYTES);

  localparam logic [7:0]  SYNC_BYTE    = 8'h55;
  localparam logic [8:0]  SUM_MOD      = 9'd255;

  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  // configuration port
  localparam int unsigned CFG_ADDR_W   = 3;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam logic        REG_TIMEOUT  = 1'b0;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_ABORT   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_SYNC1  = 3'd0,
    PH_SYNC2  = 3'd1,
    PH_HEADER = 3'd2,
    PH_DATA   = 3'd3,
    PH_CHECK  = 3'd4
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  sender_id;
    logic [7:0]  receiver_id;
    logic [7:0]  payload_byte;
    logic [15:0] payload_length;
  } slcd_result_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] payload_count;
    logic [15:0] payload_length;
  } slcd_status_t;

endpackage

// ----- hw/rtl/slcd_if.sv -----
// ----------------------------------------------------------------------------
// slcd_if
// Valid/ready stream interfaces for the deframer input and result channels.
// ----------------------------------------------------------------------------
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] byte_value;

  modport source (output valid, output op, output byte_value, input ready);
  modport sink   (input valid, input op, input byte_value, output ready);
endinterface

interface slcd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  sender_id;
  logic [7:0]  receiver_id;
  logic [7:0]  payload_byte;
  logic [15:0] payload_length;

  modport source (output valid, output kind, output sender_id, output receiver_id,
                  output payload_byte, output payload_length, input ready);
  modport sink   (input valid, input kind, input sender_id, input receiver_id,
                  input payload_byte, input payload_length, output ready);
endinterface

// ----- hw/rtl/slcd_cfg.sv -----
// ----------------------------------------------------------------------------
// slcd_cfg
// APB register block holding the frame timeout.
// ----------------------------------------------------------------------------
module slcd_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [slcd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output logic [15:0]                      timeout_o
);
  import slcd_pkg::*;

  logic [15:0] timeout_q, timeout_d;
  logic        reg_sel;
  logic        wr_en;

  // register index is the word address
  assign reg_sel = (paddr[2] == REG_TIMEOUT);
  assign wr_en   = psel && penable && pwrite && reg_sel;

  always_comb begin
    timeout_d = timeout_q;
    if (wr_en) begin
      timeout_d = pwdata[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
    end else begin
      timeout_q <= timeout_d;
    end
  end

  assign prdata    = reg_sel ? {{(CFG_DATA_W-16){1'b0}}, timeout_q} : '0;
  assign pready    = 1'b1;
  assign timeout_o = timeout_q;

endmodule

// ----- hw/rtl/slcd_parser.sv -----
// ----------------------------------------------------------------------------
// slcd_parser
// Frame parser state, running mod-255 sum and frame timer, one item a cycle.
// ----------------------------------------------------------------------------
module slcd_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic                   op_i,
  input  logic [7:0]             byte_i,
  input  logic [15:0]            timeout_i,
  output logic                   res_valid_o,
  output slcd_pkg::slcd_result_t res_o,
  output slcd_pkg::slcd_status_t status_o
);
  import slcd_pkg::*;

  phase_e               phase_q, phase_d;
  logic [HDR_IDX_W-1:0] hdr_idx_q, hdr_idx_d;
  logic [7:0]           sender_q, sender_d;
  logic [7:0]           receiver_q, receiver_d;
  logic [7:0]           len_hi_q, len_hi_d;
  logic [15:0]          length_q, length_d;
  logic [15:0]          count_q, count_d;
  logic [7:0]           sum_q, sum_d;
  logic                 timer_run_q, timer_run_d;
  logic [15:0]          timer_q, timer_d;

  logic [8:0]           sum_add;
  logic [7:0]           sum_next;
  logic [15:0]          timer_inc;
  logic                 expire;
  logic [15:0]          length_new;
  logic [15:0]          count_inc;
  logic                 is_tick;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

  assign is_tick    = (op_i == OP_TICK);
  assign sum_add    = {1'b0, sum_q} + {1'b0, byte_i};
  assign sum_next   = (sum_add >= SUM_MOD) ? 8'(sum_add - SUM_MOD) : sum_add[7:0];
  assign timer_inc  = timer_q + 16'd1;
  assign expire     = timer_run_q && (timer_inc >= timeout_i);
  assign length_new = {len_hi_q, byte_i};
  assign count_inc  = count_q + 16'd1;

  // next state
  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    sender_d    = sender_q;
    receiver_d  = receiver_q;
    len_hi_d    = len_hi_q;
    length_d    = length_q;
    count_d     = count_q;
    sum_d       = sum_q;
    timer_run_d = timer_run_q;
    timer_d     = timer_q;

    if (step_i && is_tick) begin
      if (timer_run_q) begin
        timer_d = timer_inc;
        if (expire) begin
          timer_run_d = 1'b0;
          timer_d     = '0;
          phase_d     = PH_SYNC1;
        end
      end
    end else if (step_i) begin
      unique case (phase_q)
        PH_SYNC2: begin
          if (byte_i == SYNC_BYTE) begin
            hdr_idx_d = '0;
            sum_d     = '0;
            phase_d   = PH_HEADER;
          end else begin
            phase_d = PH_SYNC1;
          end
        end
        PH_HEADER: begin
          sum_d = sum_next;
          case (hdr_idx_q)
            2'd0:    sender_d   = byte_i;
            2'd1:    receiver_d = byte_i;
            2'd2:    len_hi_d   = byte_i;
            default: length_d   = length_new;
          endcase
          if (hdr_idx_q == HDR_LAST) begin
            hdr_idx_d = '0;
            // zero length drops the frame, timer keeps going
            if (length_new != '0) begin
              count_d = '0;
              phase_d = PH_DATA;
            end else begin
              phase_d = PH_SYNC1;
            end
          end else begin
            hdr_idx_d = hdr_idx_q + 1'b1;
          end
        end
        PH_DATA: begin
          sum_d   = sum_next;
          count_d = count_inc;
          if (count_inc == length_q) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          timer_run_d = 1'b0;
          timer_d     = '0;
          phase_d     = PH_SYNC1;
        end
        default: begin
          phase_d = PH_SYNC1;
          // a sync byte restarts the timer even when running
          if (byte_i == SYNC_BYTE) begin
            phase_d     = PH_SYNC2;
            timer_run_d = 1'b1;
            timer_d     = '0;
          end
        end
      endcase
    end
  end

  // result
  always_comb begin
    res_valid_o          = 1'b0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.sender_id      = sender_q;
    res_o.receiver_id    = receiver_q;
    res_o.payload_byte   = '0;
    res_o.payload_length = length_q;
    if (step_i && is_tick) begin
      if (expire && (phase_q != PH_SYNC1)) begin
        res_valid_o = 1'b1;
        res_o.kind  = KIND_ABORT;
      end
    end else if (step_i) begin
      unique case (phase_q)
        PH_DATA: begin
          res_valid_o        = 1'b1;
          res_o.payload_byte = byte_i;
        end
        PH_CHECK: begin
          res_valid_o = 1'b1;
          res_o.kind  = (byte_i == sum_q) ? KIND_GOOD : KIND_BAD;
        end
        default: begin
          res_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SYNC1;
      hdr_idx_q   <= '0;
      sender_q    <= '0;
      receiver_q  <= '0;
      len_hi_q    <= '0;
      length_q    <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      timer_run_q <= 1'b0;
      timer_q     <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      sender_q    <= sender_d;
      receiver_q  <= receiver_d;
      len_hi_q    <= len_hi_d;
      length_q    <= length_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      timer_run_q <= timer_run_d;
      timer_q     <= timer_d;
    end
  end

  assign status_o.phase          = phase_q;
  assign status_o.payload_count  = count_q;
  assign status_o.payload_length = length_q;

endmodule

// ----- hw/rtl/sync_length_checksum_deframer_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_core
// Serial frame deframer: sync pair, header, payload, mod-255 checksum, timeout.
// ----------------------------------------------------------------------------
// One input transfer (a received byte or a timer tick) is taken every cycle
// while input ready is high; each gives zero or one result, registered for the
// next cycle. The parser update, including the mod-255 add and the 16-bit timer
// compare, is a single stage from the parser registers to the result register.
// Input ready follows the result register: it is high while the register is
// empty or being drained in the same cycle, so a stalled result sink stalls the
// input. The timeout register is set through the APB port at address 0.
module sync_length_checksum_deframer_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  slcd_in_if.sink                          in_if,
  slcd_out_if.source                       out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [slcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [slcd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import slcd_pkg::*;

  logic         accept;
  logic [15:0]  timeout;
  logic         res_valid;
  slcd_result_t res;
  slcd_status_t status;

  logic         out_valid_q, out_valid_d;
  slcd_result_t out_q, out_d;

  slcd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .timeout_o (timeout)
  );

  assign in_if.ready = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && in_if.ready;

  slcd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (accept),
    .op_i        (in_if.op),
    .byte_i      (in_if.byte_value),
    .timeout_i   (timeout),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (accept) begin
      out_valid_d = res_valid;
      out_d       = res;
    end else if (out_if.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.kind           = out_q.kind;
  assign out_if.sender_id      = out_q.sender_id;
  assign out_if.receiver_id    = out_q.receiver_id;
  assign out_if.payload_byte   = out_q.payload_byte;
  assign out_if.payload_length = out_q.payload_length;

`ifndef SYNTHESIS
  // a byte in the checksum phase always ends the frame with a verdict
  a_check_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_if.op == OP_BYTE) && (status.phase == PH_CHECK)
    |=> out_if.valid && ((out_if.kind == KIND_GOOD) || (out_if.kind == KIND_BAD)))
    else $error("checksum byte gave no verdict");

  // a held result blocks new input
  a_hold_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid && !out_if.ready |-> !in_if.ready)
    else $error("input taken while result stalled");

  // payload counter never passes the declared length
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == PH_DATA) |-> (status.payload_count < status.payload_length))
    else $error("payload count beyond length");

  // a payload result follows a byte taken in the payload phase
  a_payload_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_if.op == OP_BYTE) && (status.phase == PH_DATA)
    |=> out_if.valid && (out_if.kind == KIND_PAYLOAD)
        && (out_if.payload_byte == $past(in_if.byte_value)))
    else $error("payload byte not forwarded");
`endif

endmodule

// ----- tb/slcd_frame_checker.sv -----
// ----------------------------------------------------------------------------
// slcd_frame_checker
// Watches the deframer's byte/tick input, its result output and its APB port.
// Keeps its own copy of the parser and timer state, works out the result each
// accepted input transfer should give, and compares every result transfer
// field by field with the oldest one waiting. Timeout readbacks are checked.
// ----------------------------------------------------------------------------
module slcd_frame_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  slcd_in_if                               in_if,
  slcd_out_if                              out_if,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic                             pready,
  input  logic [slcd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]  pwdata,
  input  logic [slcd_pkg::CFG_DATA_W-1:0]  prdata,
  output int unsigned                      mismatches_o,
  output int unsigned                      outstanding_o,
  output int unsigned                      results_o,
  output int unsigned                      inputs_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import slcd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'(4 * REG_TIMEOUT);
  localparam int unsigned REPORT_LIMIT = 100;

  // predicted parser state
  logic [15:0] tmo_limit;
  phase_e      cur_phase;
  logic [1:0]  hdr_pos;
  logic [7:0]  src_id;
  logic [7:0]  dst_id;
  logic [7:0]  len_msb;
  logic [15:0] frame_len;
  logic [15:0] data_seen;
  logic [7:0]  csum;
  logic        timer_on;
  logic [15:0] timer_ticks;

  slcd_result_t frame_events_q[$];

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      mismatches_o++;
      // keep the log readable when something is badly broken
      if (mismatches_o <= REPORT_LIMIT)
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  function automatic void push_event(input kind_e kind, input logic [7:0] pbyte);
    slcd_result_t ev;
    ev.kind           = kind;
    ev.sender_id      = src_id;
    ev.receiver_id    = dst_id;
    ev.payload_byte   = pbyte;
    ev.payload_length = frame_len;
    frame_events_q.push_back(ev);
  endfunction

  function automatic logic [7:0] add_mod255(input logic [7:0] acc, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, acc} + {1'b0, b};
    if (s >= SUM_MOD) s = s - SUM_MOD;
    return s[7:0];
  endfunction

  task automatic parse_serial_item(input op_e op, input logic [7:0] b);
    if (op == OP_TICK) begin
      if (timer_on) begin
        timer_ticks = timer_ticks + 16'd1;
        if (timer_ticks >= tmo_limit) begin
          timer_on    = 1'b0;
          timer_ticks = '0;
          // expiry while waiting for a sync byte just stops the timer
          if (cur_phase != PH_SYNC1) begin
            cur_phase = PH_SYNC1;
            push_event(KIND_ABORT, 8'h00);
          end
        end
      end
    end else begin
      case (cur_phase)
        PH_SYNC2: begin
          if (b == SYNC_BYTE) begin
            hdr_pos   = '0;
            csum      = '0;
            cur_phase = PH_HEADER;
          end else begin
            cur_phase = PH_SYNC1;
          end
        end
        PH_HEADER: begin
          csum = add_mod255(csum, b);
          case (hdr_pos)
            2'd0:    src_id = b;
            2'd1:    dst_id = b;
            2'd2:    len_msb = b;
            default: frame_len = {len_msb, b};
          endcase
          if (hdr_pos >= HEADER_BYTES - 1) begin
            hdr_pos = '0;
            if (frame_len != 16'd0) begin
              data_seen = '0;
              cur_phase = PH_DATA;
            end else begin
              cur_phase = PH_SYNC1;
            end
          end else begin
            hdr_pos = hdr_pos + 2'd1;
          end
        end
        PH_DATA: begin
          csum      = add_mod255(csum, b);
          data_seen = data_seen + 16'd1;
          if (data_seen == frame_len) cur_phase = PH_CHECK;
          push_event(KIND_PAYLOAD, b);
        end
        PH_CHECK: begin
          timer_on    = 1'b0;
          timer_ticks = '0;
          cur_phase   = PH_SYNC1;
          if (b == csum) push_event(KIND_GOOD, 8'h00);
          else push_event(KIND_BAD, 8'h00);
        end
        default: begin
          cur_phase = PH_SYNC1;
          // a sync byte here restarts the timer even if it already runs
          if (b == SYNC_BYTE) begin
            cur_phase   = PH_SYNC2;
            timer_on    = 1'b1;
            timer_ticks = '0;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    slcd_result_t want;
    if (!rst_ni) begin
      tmo_limit     = TIMEOUT_RESET;
      cur_phase     = PH_SYNC1;
      hdr_pos       = '0;
      src_id        = '0;
      dst_id        = '0;
      len_msb       = '0;
      frame_len     = '0;
      data_seen     = '0;
      csum          = '0;
      timer_on      = 1'b0;
      timer_ticks   = '0;
      mismatches_o  = 0;
      results_o     = 0;
      inputs_o      = 0;
      outstanding_o <= 0;
    end else begin
      // result transfers come from earlier input transfers, so check first
      if (out_if.valid && out_if.ready) begin
        results_o++;
        if (frame_events_q.size() == 0) begin
          mismatches_o++;
          $display("%0t ns: result transfer mismatch, expected none, got kind %0d byte 0x%0h",
                   $time, out_if.kind, out_if.payload_byte);
        end else begin
          want = frame_events_q.pop_front();
          check_field("kind", want.kind, out_if.kind);
          check_field("sender_id", want.sender_id, out_if.sender_id);
          check_field("receiver_id", want.receiver_id, out_if.receiver_id);
          check_field("payload_byte", want.payload_byte, out_if.payload_byte);
          check_field("payload_length", want.payload_length, out_if.payload_length);
        end
      end
      if (in_if.valid && in_if.ready) begin
        inputs_o++;
        parse_serial_item(op_e'(in_if.op), in_if.byte_value);
      end
      if (psel && penable && pready && paddr == TIMEOUT_ADDR) begin
        if (pwrite) tmo_limit = pwdata[15:0];
        else check_field("timeout readback", {16'h0000, tmo_limit}, prdata);
      end
      outstanding_o <= frame_events_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Regression for the sync/length/checksum deframer. Sends directed frames for
// the corner cases, then random frames with noise, truncation, bad checksums
// and timer ticks under several timeout settings, with random stalls on both
// channels. Checking is done by slcd_frame_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slcd_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] TIMEOUT_ADDR = CFG_ADDR_W'(4 * REG_TIMEOUT);
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR  = TIMEOUT_ADDR + CFG_ADDR_W'(4);
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned RANDOM_ITEMS   = 420;
  localparam int unsigned NUM_SETTINGS   = 6;
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned IDLE_PCT       = 38;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  slcd_in_if  in_if ();
  slcd_out_if out_if ();

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned results_seen;
  int unsigned inputs_seen;

  int unsigned src_idle_pct = IDLE_PCT;
  int unsigned snk_idle_pct = IDLE_PCT;
  int unsigned tick_pct     = 0;
  int unsigned stream_bytes = 0;
  int unsigned cycle_cnt    = 0;
  int unsigned holdoff_req  = 0;
  int unsigned holdoff_done = 0;
  int unsigned holdoff_left = 0;
  logic [15:0] cur_timeout  = TIMEOUT_RESET;

  sync_length_checksum_deframer_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_if),
    .out_if  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slcd_frame_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .out_if        (out_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .results_o     (results_seen),
    .inputs_o      (inputs_seen)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("sync_length_checksum_deframer_core regression: fail");
      $finish;
    end
  end

  // result sink: random stalls, plus a long hold-off whenever one is requested
  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_if.ready <= 1'b0;
    end else if (holdoff_done != holdoff_req) begin
      holdoff_done++;
      holdoff_left = HOLDOFF_CYCLES;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // valid stays up after a transfer; the next call either reuses or drops it
  task automatic send_item(input op_e op, input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.op         <= op;
    in_if.byte_value <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_serial(input logic [7:0] b);
    if ($urandom_range(99) < tick_pct) send_item(OP_TICK, 8'($urandom));
    send_item(OP_BYTE, b);
    stream_bytes++;
  endtask

  task automatic send_frame(input logic [15:0] len, input bit truncate, input bit bad_sum);
    logic [7:0]  hdr [4];
    logic [7:0]  b;
    int unsigned total;
    int unsigned limit;
    int unsigned sum;
    int unsigned pos;
    hdr[0] = 8'($urandom);
    hdr[1] = 8'($urandom);
    hdr[2] = len[15:8];
    hdr[3] = len[7:0];
    // sync pair, header, payload, checksum; a zero length ends after the header
    total = (len == 16'd0) ? 6 : 7 + len;
    limit = truncate ? $urandom_range(5 + ((len > 16'd8) ? 8 : len), 1) : total;
    sum = 0;
    for (pos = 0; pos < limit; pos++) begin
      if (pos < 2) b = SYNC_BYTE;
      else if (pos < 6) b = hdr[pos-2];
      else if (pos < total - 1) b = 8'($urandom);
      else if (bad_sum) b = ($urandom_range(1) != 0) ? 8'hFF : 8'($urandom);
      else b = 8'(sum);
      if (pos >= 2 && pos < total - 1) sum = (sum + b) % 255;
      send_serial(b);
    end
  endtask

  task automatic wait_idle;
    in_if.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit is_write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timeout(input logic [15:0] value);
    apb_access(1'b1, TIMEOUT_ADDR, {16'h0000, value});
    apb_access(1'b0, TIMEOUT_ADDR, '0);
    cur_timeout = value;
  endtask

  initial begin
    logic [7:0]  opening_bytes [24];
    logic [15:0] timeout_plan [NUM_SETTINGS];
    logic [15:0] len;
    int unsigned target;
    int unsigned r;
    int unsigned i;
    bit          truncate;

    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.op         = OP_BYTE;
    in_if.byte_value = '0;
    out_if.ready     = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset value of the timeout, then a write to an address with no register
    apb_access(1'b0, TIMEOUT_ADDR, '0);
    apb_access(1'b1, UNUSED_ADDR, $urandom);
    apb_access(1'b0, TIMEOUT_ADDR, '0);

    // good frame with payload 0xff, bad frame whose checksum is 0xff,
    // zero-length frame, then a broken sync pair that leaves the timer running
    opening_bytes = '{8'h55, 8'h55, 8'hA5, 8'h5A, 8'h00, 8'h01, 8'hFF, 8'h01,
                      8'h55, 8'h55, 8'h01, 8'h02, 8'h00, 8'h01, 8'h00, 8'hFF,
                      8'h55, 8'h55, 8'hFF, 8'h00, 8'h00, 8'h00,
                      8'h55, 8'h3C};
    foreach (opening_bytes[k]) send_item(OP_BYTE, opening_bytes[k]);
    wait_idle();

    // zero timeout: first tick expires the idle timer, next one aborts a frame
    set_timeout(16'd0);
    send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_TICK, 8'hFF);

    timeout_plan = '{16'd1, 16'd7, 16'd40, 16'd65535, 16'd0, 16'd100};
    foreach (timeout_plan[p]) begin
      wait_idle();
      set_timeout(timeout_plan[p]);
      tick_pct = (cur_timeout < 16'd2) ? 2 : ((cur_timeout < 16'd10) ? 6 : 10);
      // one setting runs with no stalls at all on either side
      src_idle_pct = (cur_timeout == 16'd40) ? 0 : IDLE_PCT;
      snk_idle_pct = src_idle_pct;
      if (cur_timeout == 16'hFFFF) begin
        // long sink hold-off while a frame keeps the input busy
        holdoff_req <= holdoff_req + 1;
        send_frame(16'd40, 1'b0, 1'b0);
      end
      target = stream_bytes + RANDOM_ITEMS / NUM_SETTINGS;
      while (stream_bytes < target) begin
        if ($urandom_range(99) < 20) begin
          r = $urandom_range(3, 1);
          for (i = 0; i < r; i++) begin
            len[7:0] = 8'($urandom);
            if (len[7:0] == SYNC_BYTE) len[7:0] = ~SYNC_BYTE;
            if (i == 0 && $urandom_range(3) == 0) send_serial(SYNC_BYTE);
            send_serial(len[7:0]);
          end
        end
        r = $urandom_range(99);
        if (r < 5) len = 16'd0;
        else if (r < 10) len = 16'($urandom_range(40, 9));
        else len = 16'($urandom_range(8, 1));
        truncate = (cur_timeout <= 16'd200) && ($urandom_range(99) < 10);
        if (truncate) len = 16'($urandom);
        send_frame(len, truncate, $urandom_range(99) < 15);
        // run the timer out so the next frame starts from a clean parser
        if (truncate) repeat (cur_timeout + 1) send_item(OP_TICK, 8'($urandom));
      end
    end
    wait_idle();

    $display("covered %0d input transfers and %0d result transfers over %0d timeout settings",
             inputs_seen, results_seen, NUM_SETTINGS + 2);
    $display("frames were good, bad, truncated, zero length and timed out, with noise");
    if (mismatches == 0) begin
      $display("sync_length_checksum_deframer_core regression: pass");
    end else begin
      $display("sync_length_checksum_deframer_core regression: fail");
    end
    $finish;
  end

endmodule
